// ===== rtl/wtc_pkg.sv =====
// wtc_pkg: shared types and codes of the watch table controller.
// Request and status codes, and the command that passes from front to back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wtc_pkg;

	typedef enum logic [1:0] {
		REQ_ADD = 2'd0,
		REQ_MOD = 2'd1,
		REQ_DEL = 2'd2,
		REQ_BAD = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_BADH  = 3'd1,
		ST_INVAL = 3'd2,
		ST_FAULT = 3'd3,
		ST_EXIST = 3'd4,
		ST_NOENT = 3'd5,
		ST_FULL  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		CMD_ADD  = 2'd0,
		CMD_MOD  = 2'd1,
		CMD_DEL  = 2'd2,
		CMD_FAIL = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		status_t     fail_status;
		logic [31:0] events;
		logic [31:0] data;
	} cmd_t;

	localparam int unsigned CMD_BITS = $bits(cmd_t);
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic {
		BK_IDLE,
		BK_EXEC
	} back_state_t;

endpackage

`default_nettype wire

// ===== rtl/watch_table_control.sv =====
// watch_table_control: top level of the watch table controller.
// Joins wtc_front, wtc_queue and wtc_back. Depends on wtc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request item: type, key,
//   table handle, handle and target checks, fetch fault, event mask, data.
//   Output channel (out_valid / out_stall) returns one item per request:
//   status and the slot written or cleared.
//   The front classifies each item in the accept cycle and pushes it into a
//   two-entry queue; in_stall rises only while that queue is full.
//   The back pops one command, compares its key against every entry and
//   registers the hit and free maps; in its exec state it then picks the
//   slot, updates the table and loads the output register, waiting there
//   while the output is stalled. It takes no new command until the last one
//   has gone through the compare/update sequence.
//   Reset: all entries marked free at once, queue emptied, output invalid;
//   no clearing pass, items accepted straight after reset.
//   Output stall: the result holds; the back waits with its next command
//   and the queue keeps taking items until full.
`timescale 1ns / 1ps
`default_nettype none

module watch_table_control
	import wtc_pkg::*;
#(
	parameter int unsigned ENTRIES  = 64,
	parameter int unsigned KEY_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [7:0]  watch_key,
	input  wire logic [7:0]  table_handle,
	input  wire logic        handle_is_table,
	input  wire logic        target_open,
	input  wire logic        event_fault,
	input  wire logic [31:0] event_mask,
	input  wire logic [31:0] user_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [2:0]  status,
	output logic      [5:0]  slot_index
);

	localparam int unsigned QW = CMD_BITS + KEY_BITS;

	logic                q_full;
	logic                q_empty;
	logic                push;
	logic                pop;
	cmd_t                front_cmd;
	logic [KEY_BITS-1:0] front_key;
	logic [QW-1:0]       q_head;

	wtc_front #(
		.KEY_BITS(KEY_BITS)
	) u_front (
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.watch_key       (watch_key),
		.table_handle    (table_handle),
		.handle_is_table (handle_is_table),
		.target_open     (target_open),
		.event_fault     (event_fault),
		.event_mask      (event_mask),
		.user_data       (user_data),
		.q_full          (q_full),
		.push            (push),
		.cmd             (front_cmd),
		.cmd_key         (front_key)
	);

	wtc_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({front_cmd, front_key}),
		.pop       (pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	wtc_back #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_cmd      (cmd_t'(q_head[QW-1:KEY_BITS])),
		.q_key      (q_head[KEY_BITS-1:0]),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.slot_index (slot_index)
	);

endmodule

`default_nettype wire

// ===== rtl/wtc_ram.sv =====
// wtc_ram: generic single write port RAM with one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wtc_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/wtc_front.sv =====
// wtc_front: accepts request items and classifies them into table commands.
// Runs the handle, self-watch, fault and opcode checks. Depends on wtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtc_front
	import wtc_pkg::*;
#(
	parameter int unsigned KEY_BITS = 8
) (
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          req_type,
	input  wire logic [7:0]          watch_key,
	input  wire logic [7:0]          table_handle,
	input  wire logic                handle_is_table,
	input  wire logic                target_open,
	input  wire logic                event_fault,
	input  wire logic [31:0]         event_mask,
	input  wire logic [31:0]         user_data,
	input  wire logic                q_full,
	output logic                     push,
	output cmd_t                     cmd,
	output logic      [KEY_BITS-1:0] cmd_key
);

	logic [KEY_BITS-1:0] handle_key;
	req_t                req;

	assign cmd_key    = KEY_BITS'(watch_key);
	assign handle_key = KEY_BITS'(table_handle);
	assign req        = req_t'(req_type);
	assign in_stall   = q_full;
	assign push       = in_valid && !q_full;

	always_comb begin
		cmd.events      = event_mask;
		cmd.data        = user_data;
		cmd.kind        = CMD_FAIL;
		cmd.fail_status = ST_INVAL;
		if (!handle_is_table || !target_open) begin
			cmd.fail_status = ST_BADH;
		end else if (cmd_key == handle_key) begin
			cmd.fail_status = ST_INVAL;
		end else if (req != REQ_DEL && event_fault) begin
			cmd.fail_status = ST_FAULT;
		end else begin
			case (req)
				REQ_ADD: cmd.kind = CMD_ADD;
				REQ_MOD: cmd.kind = CMD_MOD;
				REQ_DEL: cmd.kind = CMD_DEL;
				default: cmd.kind = CMD_FAIL;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/wtc_queue.sv =====
// wtc_queue: short first-in first-out queue between front and back.
// Generic width; depth from wtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtc_queue
	import wtc_pkg::*;
#(
	parameter int unsigned WIDTH = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] head,
	output logic                  full,
	output logic                  empty
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head  = slot_q[rd_ptr_q];
	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/wtc_back.sv =====
// wtc_back: carries out table commands against the entry store.
// Key compare and free map registered on pop; slot pick, update, result in exec.
// Depends on wtc_pkg and wtc_ram.
`timescale 1ns / 1ps
`default_nettype none

module wtc_back
	import wtc_pkg::*;
#(
	parameter int unsigned ENTRIES  = 64,
	parameter int unsigned KEY_BITS = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_empty,
	input  wire cmd_t                q_cmd,
	input  wire logic [KEY_BITS-1:0] q_key,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [2:0]          status,
	output logic      [5:0]          slot_index
);

	localparam int unsigned IDX_W = $clog2(ENTRIES);

	back_state_t         state_q;
	back_state_t         state_d;
	logic [ENTRIES-1:0]  used_q;
	logic [KEY_BITS-1:0] key_q [ENTRIES];

	cmd_t                cmd_s1;
	logic [KEY_BITS-1:0] key_s1;
	logic [ENTRIES-1:0]  hit_s1;
	logic [ENTRIES-1:0]  free_s1;

	logic [ENTRIES-1:0]  hit_vec;
	logic [IDX_W-1:0]    hit_idx;
	logic [IDX_W-1:0]    free_idx;
	logic                any_hit;
	logic                any_free;

	logic                out_valid_q;
	status_t             status_q;
	logic [5:0]          slot_q;

	logic                out_free;
	logic                exec;
	status_t             res_status;
	logic [IDX_W-1:0]    res_idx;
	logic                res_write;
	logic [63:0]         ram_wdata;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i] = used_q[i] && (key_q[i] == q_key);
		end
	end

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (hit_s1[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (free_s1[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign any_hit  = |hit_s1;
	assign any_free = |free_s1;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		res_status = cmd_s1.fail_status;
		res_idx    = '0;
		res_write  = 1'b0;
		case (cmd_s1.kind)
			CMD_ADD: begin
				if (any_hit) begin
					res_status = ST_EXIST;
				end else if (!any_free) begin
					res_status = ST_FULL;
				end else begin
					res_status = ST_OK;
					res_idx    = free_idx;
					res_write  = 1'b1;
				end
			end
			CMD_MOD, CMD_DEL: begin
				if (!any_hit) begin
					res_status = ST_NOENT;
				end else begin
					res_status = ST_OK;
					res_idx    = hit_idx;
					res_write  = 1'b1;
				end
			end
			default: res_status = cmd_s1.fail_status;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (!q_empty) state_d = BK_EXEC;
			BK_EXEC: if (out_free) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop  = 1'b0;
		exec = 1'b0;
		case (state_q)
			BK_IDLE: pop  = !q_empty;
			BK_EXEC: exec = out_free;
			default: begin
				pop  = 1'b0;
				exec = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (exec && res_write) begin
				case (cmd_s1.kind)
					CMD_ADD: used_q[res_idx] <= 1'b1;
					CMD_DEL: used_q[res_idx] <= 1'b0;
					default: used_q[res_idx] <= used_q[res_idx];
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1  <= q_cmd;
			key_s1  <= q_key;
			hit_s1  <= hit_vec;
			free_s1 <= ~used_q;
		end
		if (exec && res_write && cmd_s1.kind == CMD_ADD) begin
			key_q[res_idx] <= key_s1;
		end
		if (exec) begin
			status_q <= res_status;
			slot_q   <= res_write ? 6'(res_idx) : 6'd0;
		end
	end

	assign ram_wdata = (cmd_s1.kind == CMD_DEL) ? 64'd0 : {cmd_s1.events, cmd_s1.data};

	wtc_ram #(
		.WIDTH(64),
		.DEPTH(ENTRIES)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (exec && res_write),
		.wr_addr (res_idx),
		.wr_data (ram_wdata),
		.rd_en   (1'b0),
		.rd_addr (res_idx),
		.rd_data ()
	);

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot_index = slot_q;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// testbench: self-checking bench for watch_table_control.
// Predicts status and slot of every request from its own copy of the watch
// table and checks each result in order. Depends on wtc_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
	import wtc_pkg::*;

	localparam int unsigned SLOTS      = 64;
	localparam int unsigned STALL_PCT  = 15;
	localparam int unsigned HANG_LIMIT = 2000;
	localparam int unsigned DRAIN_WAIT = 8;

	typedef struct packed {
		req_t        op;
		logic [7:0]  key;
		logic [7:0]  handle;
		logic        tbl_ok;
		logic        target_up;
		logic        fault;
		logic [31:0] mask;
		logic [31:0] data;
	} request_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  slot;
	} reply_t;

	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        in_valid        = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type        = REQ_ADD;
	logic [7:0]  watch_key       = 8'h00;
	logic [7:0]  table_handle    = 8'h00;
	logic        handle_is_table = 1'b0;
	logic        target_open     = 1'b0;
	logic        event_fault     = 1'b0;
	logic [31:0] event_mask      = 32'h0;
	logic [31:0] user_data       = 32'h0;
	logic        out_valid;
	logic        out_stall       = 1'b0;
	logic [2:0]  status;
	logic [5:0]  slot_index;

	logic        idle_enable     = 1'b1;
	int unsigned fail_count      = 0;
	int unsigned quiet_cycles    = 0;
	reply_t      replies_due[$];

	logic        ent_used [SLOTS];
	logic [7:0]  ent_key [SLOTS];
	logic [31:0] ent_events [SLOTS];
	logic [31:0] ent_data [SLOTS];

	watch_table_control dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.watch_key       (watch_key),
		.table_handle    (table_handle),
		.handle_is_table (handle_is_table),
		.target_open     (target_open),
		.event_fault     (event_fault),
		.event_mask      (event_mask),
		.user_data       (user_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.slot_index      (slot_index)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic reply_t predict_request(input request_t r);
		reply_t rep;
		int     hit;
		int     free_slot;
		rep.status = ST_OK;
		rep.slot   = '0;
		hit        = -1;
		free_slot  = -1;
		if (!r.tbl_ok || !r.target_up) begin
			rep.status = ST_BADH;
			return rep;
		end
		if (r.key == r.handle) begin
			rep.status = ST_INVAL;
			return rep;
		end
		if (r.op != REQ_DEL && r.fault) begin
			rep.status = ST_FAULT;
			return rep;
		end
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (ent_used[i] && ent_key[i] == r.key)
				hit = i;
			if (!ent_used[i])
				free_slot = i;
		end
		case (r.op)
			REQ_ADD: begin
				if (hit >= 0)
					rep.status = ST_EXIST;
				else if (free_slot < 0)
					rep.status = ST_FULL;
				else begin
					ent_used[free_slot]   = 1'b1;
					ent_key[free_slot]    = r.key;
					ent_events[free_slot] = r.mask;
					ent_data[free_slot]   = r.data;
					rep.slot              = 6'(free_slot);
				end
			end
			REQ_MOD: begin
				if (hit < 0)
					rep.status = ST_NOENT;
				else begin
					ent_events[hit] = r.mask;
					ent_data[hit]   = r.data;
					rep.slot        = 6'(hit);
				end
			end
			REQ_DEL: begin
				if (hit < 0)
					rep.status = ST_NOENT;
				else begin
					ent_used[hit]   = 1'b0;
					ent_key[hit]    = '0;
					ent_events[hit] = '0;
					ent_data[hit]   = '0;
					rep.slot        = 6'(hit);
				end
			end
			default: rep.status = ST_INVAL;
		endcase
		return rep;
	endfunction

	function automatic request_t make_request(input req_t op, input logic [7:0] key,
			input logic [7:0] handle, input logic tbl_ok, input logic target_up,
			input logic fault, input logic [31:0] mask, input logic [31:0] data);
		request_t r;
		r.op        = op;
		r.key       = key;
		r.handle    = handle;
		r.tbl_ok    = tbl_ok;
		r.target_up = target_up;
		r.fault     = fault;
		r.mask      = mask;
		r.data      = data;
		return r;
	endfunction

	// Bias keys towards entries in use so that hits, duplicates and a full table occur.
	function automatic request_t random_request(input int unsigned add_pct);
		request_t    r;
		int unsigned pick;
		int unsigned s;
		pick = $urandom_range(0, 99);
		if (pick < add_pct)
			r.op = REQ_ADD;
		else if (pick < 95)
			r.op = $urandom_range(0, 1) ? REQ_MOD : REQ_DEL;
		else
			r.op = req_t'($urandom_range(0, 3));
		pick = $urandom_range(0, 99);
		s    = $urandom_range(0, SLOTS - 1);
		if (pick < 55 && ent_used[s])
			r.key = ent_key[s];
		else if (pick < 75)
			r.key = 8'($urandom_range(0, 15));
		else
			r.key = 8'($urandom);
		r.handle    = ($urandom_range(0, 99) < 3) ? r.key : 8'($urandom);
		r.tbl_ok    = $urandom_range(0, 99) < 95;
		r.target_up = $urandom_range(0, 99) < 95;
		r.fault     = $urandom_range(0, 99) < 5;
		r.mask      = $urandom;
		r.data      = $urandom;
		return r;
	endfunction

	task automatic send_request(input request_t r);
		while (idle_enable && $urandom_range(0, 99) < STALL_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		req_type        <= r.op;
		watch_key       <= r.key;
		table_handle    <= r.handle;
		handle_is_table <= r.tbl_ok;
		target_open     <= r.target_up;
		event_fault     <= r.fault;
		event_mask      <= r.mask;
		user_data       <= r.data;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic test_directed;
		send_request(make_request(REQ_ADD, 8'h00, 8'hFF, 1, 1, 0, 32'hFFFF_FFFF, 32'h0));
		send_request(make_request(REQ_ADD, 8'hFF, 8'h00, 1, 1, 0, 32'h0, 32'hFFFF_FFFF));
		send_request(make_request(REQ_ADD, 8'h00, 8'h80, 1, 1, 0, 32'h1, 32'h2));
		send_request(make_request(REQ_ADD, 8'h20, 8'h80, 0, 1, 0, 32'h3, 32'h4));
		send_request(make_request(REQ_MOD, 8'h00, 8'h80, 1, 0, 0, 32'h5, 32'h6));
		send_request(make_request(REQ_DEL, 8'h5A, 8'h5A, 0, 0, 1, 32'h7, 32'h8));
		send_request(make_request(REQ_ADD, 8'h5A, 8'h5A, 1, 1, 0, 32'h9, 32'hA));
		send_request(make_request(REQ_BAD, 8'hA5, 8'hA5, 1, 1, 1, 32'hB, 32'hC));
		send_request(make_request(REQ_ADD, 8'h20, 8'h80, 1, 1, 1, 32'hD, 32'hE));
		send_request(make_request(REQ_MOD, 8'h00, 8'h80, 1, 1, 1, 32'hF, 32'h10));
		send_request(make_request(REQ_BAD, 8'h20, 8'h80, 1, 1, 1, 32'h11, 32'h12));
		send_request(make_request(REQ_BAD, 8'h20, 8'h80, 1, 1, 0, 32'h13, 32'h14));
		send_request(make_request(REQ_DEL, 8'hFF, 8'h80, 1, 1, 1, 32'h15, 32'h16));
		send_request(make_request(REQ_MOD, 8'h00, 8'h80, 1, 1, 0, 32'h0, 32'hFFFF_FFFF));
		send_request(make_request(REQ_MOD, 8'h33, 8'h80, 1, 1, 0, 32'hFFFF_FFFF, 32'h0));
		send_request(make_request(REQ_DEL, 8'h33, 8'h80, 1, 1, 0, 32'h17, 32'h18));
		send_request(make_request(REQ_ADD, 8'h33, 8'h80, 1, 1, 0, 32'hAAAA_5555, 32'h5555_AAAA));
		send_request(make_request(REQ_DEL, 8'h00, 8'h80, 1, 1, 0, 32'h19, 32'h1A));
		send_request(make_request(REQ_ADD, 8'h44, 8'h80, 1, 1, 0, 32'h1B, 32'h1C));
		send_request(make_request(REQ_DEL, 8'h00, 8'h80, 1, 1, 0, 32'h1D, 32'h1E));
	endtask

	// Fill every slot, overflow, free a few and refill, then empty the table.
	task automatic test_full_table;
		int unsigned n;
		for (int i = 0; i < SLOTS + 4; i++)
			send_request(make_request(REQ_ADD, 8'(8'hA0 + i), 8'h10, 1, 1, 0,
				$urandom, $urandom));
		for (int i = 0; i < 6; i++) begin
			n = $urandom_range(0, SLOTS - 1);
			send_request(make_request(REQ_DEL, 8'(8'hA0 + n), 8'h10, 1, 1,
				1'($urandom), $urandom, $urandom));
		end
		for (int i = 0; i < 8; i++)
			send_request(make_request(REQ_ADD, 8'(8'hA0 + $urandom_range(0, SLOTS + 3)),
				8'h10, 1, 1, 0, $urandom, $urandom));
		for (int i = 0; i < SLOTS + 4; i++)
			send_request(make_request(REQ_DEL, 8'(8'hA0 + i), 8'h10, 1, 1, 0,
				$urandom, $urandom));
	endtask

	task automatic test_back_to_back;
		idle_enable <= 1'b0;
		for (int i = 0; i < 150; i++)
			send_request(random_request(50));
		idle_enable <= 1'b1;
	endtask

	// Alternate fill-heavy and drain-heavy phases so the table swings between empty and full.
	task automatic test_random_mix;
		int unsigned add_pct;
		add_pct = 70;
		for (int i = 0; i < 850; i++) begin
			if (i % 120 == 0)
				add_pct = ((i / 120) % 2 == 0) ? 75 : 20;
			send_request(random_request(add_pct));
		end
	endtask

	always @(posedge clk) begin
		out_stall <= idle_enable && ($urandom_range(0, 99) < STALL_PCT);
	end

	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (in_valid && !in_stall)
			replies_due.push_back(predict_request(make_request(req_t'(req_type), watch_key,
				table_handle, handle_is_table, target_open, event_fault, event_mask,
				user_data)));
		if (out_valid && !out_stall) begin
			got.status = status_t'(status);
			got.slot   = slot_index;
			if (replies_due.size() == 0) begin
				$error("result with no request pending: status %0d slot %0d",
					status, slot_index);
				fail_count++;
			end else begin
				want = replies_due.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (got.slot !== want.slot) begin
					$error("slot_index: expected %0d, got %0d", want.slot, slot_index);
					fail_count++;
				end
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			ent_used[i]   = 1'b0;
			ent_key[i]    = '0;
			ent_events[i] = '0;
			ent_data[i]   = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_back_to_back();
		test_random_mix();
		in_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (replies_due.size() != 0) begin
			$error("%0d results never arrived", replies_due.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
